/* sv/brle_pkg.sv */
// Shared types and constants for the byte run-length encoder.
// Used by byte_run_length_encoder_core; no dependencies.
package brle_pkg;

  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 8;   // group counts and header bytes
  localparam int TR_W       = 2;   // tail run length
  localparam int BL_W       = 4;   // bits left in the bit accumulator
  localparam int PACK_BYTES = 8;
  localparam int WORD_W     = PACK_BYTES * BYTE_W;
  localparam int PCNT_W     = 4;   // bytes held in a result word, 0..8

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_GROUP = 6'b000010,
    S_HDR   = 6'b000100,
    S_VAL   = 6'b001000,
    S_LIT   = 6'b010000,
    S_END   = 6'b100000
  } state_t;

  // one group to send out: header byte, then the value or the stored literals
  typedef struct packed {
    logic  lit;
    byte_t hdr;
    byte_t val;
    cnt_t  len;
  } emit_t;

endpackage

/* sv/brle_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module brle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* sv/byte_run_length_encoder_core.sv */
// Byte run-length encoder: literal groups and repeat runs, header byte first.
// Depends on brle_pkg and brle_ram (literal group store).
//
// Each accepted request is a data byte (tuser = 0) or a flush (tuser = 1); in
// boolean mode bit 0 of each data byte is packed MSB-first and every eighth bit
// is encoded as one byte. Encoded bytes leave packed eight to a 72-bit result
// word, earliest byte lowest, with tlast on the final word of each request.
// A data request that sends nothing out is taken in S_IDLE alone. A request that
// sends out a group goes from S_IDLE to S_HDR and then S_VAL or S_LIT, sending
// each encoded byte in turn (header, then the repeat value or each literal read
// from the group store, one RAM read per cycle), then S_END hands over the final
// word. A flush always passes through S_GROUP to close the pending group, so a
// flush with nothing pending sends nothing, and a flush whose partial byte also
// ends a group sends that group first, then closes the pending one. No request
// is taken while bytes are going out; back-pressure on the result side stalls
// the byte stream, which pauses while a full word waits behind an occupied output
// register, and the final word waits for the output register to be free.
module byte_run_length_encoder_core #(
  parameter int MAX_LITERAL = 128,
  parameter int MIN_REPEAT  = 3,
  parameter int MAX_REPEAT  = 130
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,    // bool_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] value
  input  logic [0:0]  s_axis_tuser,   // [0] action (1 = flush)
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [63:0] out_word, [67:64] byte_count, [71:68] zero
  output logic        m_axis_tlast    // last
);

  import brle_pkg::*;

  localparam int ADDR_W = $clog2(MAX_LITERAL);
  localparam cnt_t MIN_R  = CNT_W'(MIN_REPEAT);
  localparam cnt_t MAX_R  = CNT_W'(MAX_REPEAT);
  localparam cnt_t MAX_L  = CNT_W'(MAX_LITERAL);
  localparam logic [TR_W-1:0] TR_MIN = TR_W'(MIN_REPEAT);
  localparam logic [BL_W-1:0] BL_FULL = BL_W'(BYTE_W);
  localparam logic [PCNT_W-1:0] PCNT_FULL = PCNT_W'(PACK_BYTES);

  // control and encoder state
  state_t            state, state_next;
  logic              bool_mode;
  cnt_t              gc, gc_next;
  logic              rep, rep_next;
  logic [TR_W-1:0]   tr, tr_next;
  byte_t             lastv, lastv_next;
  byte_t             acc, acc_next;
  logic [BL_W-1:0]   bits_left, bits_left_next;
  logic              grp_pend, grp_pend_next;
  emit_t             em, em_next;
  logic [ADDR_W-1:0] lit_idx, lit_idx_next;

  // packing and output
  logic [WORD_W-1:0] pack, pack_next;
  logic [PCNT_W-1:0] cnt, cnt_next;
  logic              m_valid, m_valid_next;
  logic [WORD_W-1:0] out_word, out_word_next;
  logic [PCNT_W-1:0] out_cnt, out_cnt_next;
  logic              out_last, out_last_next;

  // RAM
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  byte_t             ram_rdata;

  // encoder datapath
  logic              flush;
  logic [BL_W-1:0]   bl_dec;
  byte_t             acc_bit;
  byte_t             enc_v;
  logic              enc_emit, enc_we;
  logic [ADDR_W-1:0] enc_waddr;
  emit_t             enc_em;
  cnt_t              gc_e, gc_inc;
  logic              rep_e;
  logic [TR_W-1:0]   tr_e, tr_inc;
  emit_t             grp_em;

  logic              accept, out_free, byte_ok, push;
  byte_t             push_byte;

  brle_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_LITERAL)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (lastv_next),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign flush    = s_axis_tuser[0];
  assign out_free = !m_valid || m_axis_tready;
  assign byte_ok  = (cnt != PCNT_FULL) || out_free;

  // boolean mode: next bit position and accumulator with this bit set
  assign bl_dec  = {1'b0, 3'(bits_left - BL_W'(1))};
  assign acc_bit = acc | (byte_t'(s_axis_tdata[0]) << bl_dec[2:0]);
  assign enc_v   = flush ? acc : (bool_mode ? acc_bit : s_axis_tdata);

  assign gc_inc = gc + cnt_t'(1);
  assign tr_inc = (enc_v == lastv) ? tr + TR_W'(1) : TR_W'(1);

  // one byte into the group state
  always_comb begin
    enc_emit   = 1'b0;
    enc_em.lit = 1'b0;
    enc_em.hdr = '0;
    enc_em.val = lastv;
    enc_em.len = '0;
    enc_we     = 1'b0;
    enc_waddr  = '0;
    gc_e       = gc;
    rep_e      = rep;
    tr_e       = tr;
    if (gc == '0) begin
      enc_we = 1'b1;
      gc_e   = cnt_t'(1);
      tr_e   = TR_W'(1);
      rep_e  = 1'b0;
    end else if (rep) begin
      if (enc_v == lastv) begin
        gc_e = gc_inc;
        if (gc_inc >= MAX_R) begin
          enc_emit   = 1'b1;
          enc_em.hdr = gc_inc - MIN_R;
          gc_e       = '0;
          rep_e      = 1'b0;
          tr_e       = '0;
        end
      end else begin
        // run broken: send it, start a fresh group with this byte
        enc_emit   = 1'b1;
        enc_em.hdr = gc - MIN_R;
        enc_we     = 1'b1;
        gc_e       = cnt_t'(1);
        tr_e       = TR_W'(1);
        rep_e      = 1'b0;
      end
    end else if (tr_inc >= TR_MIN) begin
      // literal tail turns into a run; send what precedes it
      if (gc >= MIN_R) begin
        enc_emit   = 1'b1;
        enc_em.lit = 1'b1;
        enc_em.len = gc - (MIN_R - cnt_t'(1));
        enc_em.hdr = cnt_t'(0) - enc_em.len;
      end
      rep_e = 1'b1;
      tr_e  = TR_MIN;
      gc_e  = MIN_R;
    end else begin
      enc_we    = 1'b1;
      enc_waddr = gc[ADDR_W-1:0];
      gc_e      = gc_inc;
      tr_e      = tr_inc;
      if (gc_inc >= MAX_L) begin
        enc_emit   = 1'b1;
        enc_em.lit = 1'b1;
        enc_em.len = gc_inc;
        enc_em.hdr = cnt_t'(0) - gc_inc;
        gc_e       = '0;
        tr_e       = '0;
        rep_e      = 1'b0;
      end
    end
  end

  // closing the pending group
  always_comb begin
    grp_em.lit = !rep;
    grp_em.hdr = rep ? (gc - MIN_R) : (cnt_t'(0) - gc);
    grp_em.val = lastv;
    grp_em.len = gc;
  end

  // sequencer
  always_comb begin
    state_next     = state;
    gc_next        = gc;
    rep_next       = rep;
    tr_next        = tr;
    lastv_next     = lastv;
    acc_next       = acc;
    bits_left_next = bits_left;
    grp_pend_next  = grp_pend;
    em_next        = em;
    lit_idx_next   = lit_idx;
    s_axis_tready  = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = enc_waddr;
    ram_raddr      = lit_idx;
    push           = 1'b0;
    push_byte      = em.hdr;
    case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (accept) begin
          if (!flush && bool_mode && bl_dec != '0) begin
            acc_next       = acc_bit;
            bits_left_next = bl_dec;
          end else if (flush && bits_left == BL_FULL) begin
            state_next = S_GROUP;
          end else begin
            if (flush || bool_mode) begin
              acc_next       = '0;
              bits_left_next = BL_FULL;
            end
            gc_next    = gc_e;
            rep_next   = rep_e;
            tr_next    = tr_e;
            lastv_next = enc_v;
            ram_we     = enc_we;
            if (enc_emit) begin
              em_next       = enc_em;
              grp_pend_next = flush;
              state_next    = S_HDR;
            end else if (flush) begin
              state_next = S_GROUP;
            end
          end
        end
      end
      S_GROUP: begin
        grp_pend_next = 1'b0;
        if (gc != '0) begin
          em_next    = grp_em;
          gc_next    = '0;
          rep_next   = 1'b0;
          tr_next    = '0;
          state_next = S_HDR;
        end else begin
          state_next = S_END;
        end
      end
      S_HDR: begin
        push         = byte_ok;
        push_byte    = em.hdr;
        lit_idx_next = '0;
        ram_raddr    = '0;
        if (byte_ok) begin
          state_next = em.lit ? S_LIT : S_VAL;
        end
      end
      S_VAL: begin
        push      = byte_ok;
        push_byte = em.val;
        if (byte_ok) begin
          state_next    = grp_pend ? S_GROUP : S_END;
          grp_pend_next = 1'b0;
        end
      end
      S_LIT: begin
        push      = byte_ok;
        push_byte = ram_rdata;
        if (byte_ok) begin
          // read one ahead so a byte can leave every cycle while the output keeps up
          ram_raddr    = lit_idx + ADDR_W'(1);
          lit_idx_next = lit_idx + ADDR_W'(1);
          if (lit_idx == ADDR_W'(em.len - cnt_t'(1))) begin
            state_next    = grp_pend ? S_GROUP : S_END;
            grp_pend_next = 1'b0;
          end
        end
      end
      S_END: begin
        if (cnt == '0 || out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // word packing; a full word is held back until it is known not to be last
  always_comb begin
    pack_next     = pack;
    cnt_next      = cnt;
    m_valid_next  = m_valid && !m_axis_tready;
    out_word_next = out_word;
    out_cnt_next  = out_cnt;
    out_last_next = out_last;
    if (push) begin
      if (cnt == PCNT_FULL) begin
        m_valid_next  = 1'b1;
        out_word_next = pack;
        out_cnt_next  = cnt;
        out_last_next = 1'b0;
        pack_next     = WORD_W'(push_byte);
        cnt_next      = PCNT_W'(1);
      end else if (cnt == '0) begin
        pack_next = WORD_W'(push_byte);
        cnt_next  = PCNT_W'(1);
      end else begin
        pack_next[cnt[2:0]*BYTE_W +: BYTE_W] = push_byte;
        cnt_next = cnt + PCNT_W'(1);
      end
    end else if (state == S_END && cnt != '0 && out_free) begin
      m_valid_next  = 1'b1;
      out_word_next = pack;
      out_cnt_next  = cnt;
      out_last_next = 1'b1;
      cnt_next      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bool_mode <= 1'b0;
      gc        <= '0;
      rep       <= 1'b0;
      tr        <= '0;
      acc       <= '0;
      bits_left <= BL_FULL;
      grp_pend  <= 1'b0;
      cnt       <= '0;
      m_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      if (cfg_wr_en) begin
        bool_mode <= cfg_wr_data;
      end
      gc        <= gc_next;
      rep       <= rep_next;
      tr        <= tr_next;
      acc       <= acc_next;
      bits_left <= bits_left_next;
      grp_pend  <= grp_pend_next;
      cnt       <= cnt_next;
      m_valid   <= m_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    lastv    <= lastv_next;
    em       <= em_next;
    lit_idx  <= lit_idx_next;
    pack     <= pack_next;
    out_word <= out_word_next;
    out_cnt  <= out_cnt_next;
    out_last <= out_last_next;
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {4'b0000, out_cnt, out_word};
  assign m_axis_tlast  = out_last;

endmodule

/* sim/byte_run_length_encoder_core_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for byte_run_length_encoder_core: byte and boolean streams,
// flushes and mode changes, with random idling on both stream sides.
// Depends on brle_pkg and the encoder RTL only.
module byte_run_length_encoder_core_test;
  import brle_pkg::*;

  localparam int MAX_LITERAL   = 128;
  localparam int MIN_REPEAT    = 3;
  localparam int MAX_REPEAT    = 130;
  localparam int HOLD_LEN      = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1000000;

  localparam logic ACT_DATA  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef struct packed {
    logic  act;
    byte_t val;
  } enc_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [PCNT_W-1:0] nbytes;
    logic              last;
  } rle_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // [7:0] value
  logic [0:0]  s_axis_tuser = '0;    // [0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;         // [63:0] out_word, [67:64] byte_count, [71:68] zero
  logic        m_axis_tlast;

  byte_run_length_encoder_core #(
    .MAX_LITERAL(MAX_LITERAL),
    .MIN_REPEAT (MIN_REPEAT),
    .MAX_REPEAT (MAX_REPEAT)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk = ~clk;

  enc_req_t  pending_reqs[$];
  rle_word_t words_due[$];

  // encoder state as predicted
  logic  bool_mode_q = 1'b0;
  byte_t lit_store [MAX_LITERAL];
  int    grp_cnt = 0;
  bit    in_repeat = 1'b0;
  int    tail_len = 0;
  byte_t bit_acc = '0;
  int    bits_free = 8;
  byte_t enc_bytes[$];

  int reqs_sent = 0;
  int flushes_sent = 0;
  int words_seen = 0;
  int mismatches = 0;
  int cycle_cnt = 0;
  int src_wait = 0;
  int snk_wait = 0;
  int calm_src = 0;
  int calm_snk = 0;

  logic hold_armed = 1'b0;
  int   hold_cycles = 0;
  logic long_hold;

  // ---------------------------------------------------------------- predictor
  task automatic close_group();
    int i;
    if (grp_cnt != 0) begin
      if (in_repeat) begin
        enc_bytes.push_back(byte_t'(grp_cnt - MIN_REPEAT));
        enc_bytes.push_back(lit_store[0]);
      end else begin
        enc_bytes.push_back(byte_t'(256 - grp_cnt));
        for (i = 0; i < grp_cnt; i++) enc_bytes.push_back(lit_store[i]);
      end
      in_repeat = 1'b0;
      tail_len  = 0;
      grp_cnt   = 0;
    end
  endtask

  task automatic encode_value(input byte_t v);
    if (grp_cnt == 0) begin
      lit_store[0] = v;
      grp_cnt  = 1;
      tail_len = 1;
    end else if (in_repeat) begin
      if (v == lit_store[0]) begin
        grp_cnt++;
        if (grp_cnt >= MAX_REPEAT) close_group();
      end else begin
        close_group();
        lit_store[0] = v;
        grp_cnt  = 1;
        tail_len = 1;
      end
    end else begin
      if (v == lit_store[grp_cnt-1]) tail_len++;
      else tail_len = 1;
      if (tail_len >= MIN_REPEAT) begin
        // the repeated tail leaves the literal group and becomes a run
        if (grp_cnt + 1 > MIN_REPEAT) begin
          grp_cnt -= MIN_REPEAT - 1;
          close_group();
          lit_store[0] = v;
        end
        in_repeat = 1'b1;
        tail_len  = MIN_REPEAT;
        grp_cnt   = MIN_REPEAT;
      end else begin
        lit_store[grp_cnt] = v;
        grp_cnt++;
        if (grp_cnt >= MAX_LITERAL) close_group();
      end
    end
  endtask

  task automatic push_partial();
    encode_value(bit_acc);
    bits_free = 8;
    bit_acc   = '0;
  endtask

  task automatic predict_request(input logic act, input byte_t v);
    rle_word_t w;
    int        k;
    w = '0;
    enc_bytes.delete();
    if (act == ACT_FLUSH) begin
      if (bits_free != 8) push_partial();
      close_group();
    end else if (bool_mode_q) begin
      bits_free = (bits_free - 1) & 7;
      bit_acc   = bit_acc | (byte_t'(v[0]) << bits_free);
      if (bits_free == 0) push_partial();
    end else begin
      encode_value(v);
    end
    for (k = 0; k < enc_bytes.size(); k++) begin
      if (k % 8 == 0) w = '0;
      w.word[8*(k%8) +: 8] = enc_bytes[k];
      w.nbytes = w.nbytes + 1'b1;
      if (k % 8 == 7 || k == enc_bytes.size() - 1) begin
        w.last = (k == enc_bytes.size() - 1);
        words_due.push_back(w);
      end
    end
  endtask

  // ---------------------------------------------------------------- stimulus
  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      pick_wait = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      pick_wait = 0;
    end else begin
      pick_wait = $urandom_range(0, 10);
    end
  endfunction

  function automatic byte_t pick_byte();
    case ($urandom_range(0, 5))
      0:       pick_byte = 8'h00;
      1:       pick_byte = 8'hFF;
      default: pick_byte = byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_req(input logic act, input byte_t v);
    pending_reqs.push_back('{act: act, val: v});
  endtask

  task automatic queue_run(input byte_t v, input int n);
    repeat (n) queue_req(ACT_DATA, v);
  endtask

  // no two neighbours equal, so no run forms within the bytes
  task automatic queue_literals(input int n);
    byte_t v, prev;
    prev = pick_byte();
    repeat (n) begin
      v = pick_byte();
      if (v == prev) v = ~v;
      queue_req(ACT_DATA, v);
      prev = v;
    end
  endtask

  // top n bits of pattern, MSB first, in bit 0 of otherwise random bytes
  task automatic queue_bits(input byte_t pattern, input int n);
    int    i;
    byte_t v;
    for (i = 7; i > 7 - n; i--) begin
      v = byte_t'($urandom_range(0, 255));
      v[0] = pattern[i];
      queue_req(ACT_DATA, v);
    end
  endtask

  task automatic queue_byte_stream(input int target, input bit with_caps);
    int added, len, kind;
    bit lit_done, run_done;
    added    = 0;
    lit_done = !with_caps;
    run_done = !with_caps;
    while (added < target) begin
      kind = $urandom_range(0, 9);
      if (!lit_done && added >= 30) begin
        len = MAX_LITERAL + 1;
        queue_literals(len);
        lit_done = 1'b1;
      end else if (!run_done && added >= 180) begin
        len = MAX_REPEAT + 2;
        queue_run(pick_byte(), len);
        run_done = 1'b1;
      end else if (kind < 4) begin
        len = $urandom_range(1, 6);
        queue_run(pick_byte(), len);
      end else if (kind < 7) begin
        len = $urandom_range(1, 10);
        queue_literals(len);
      end else if (kind == 7) begin
        len = 1;
        queue_req(ACT_FLUSH, pick_byte());
      end else begin
        // short noise over a two-value alphabet
        len = $urandom_range(1, 5);
        repeat (len) queue_req(ACT_DATA, byte_t'($urandom_range(0, 1)));
      end
      added += len;
    end
  endtask

  task automatic queue_bit_stream(input int target);
    int    added, kind, reps, nbits;
    byte_t p;
    added = 0;
    while (added < target) begin
      kind = $urandom_range(0, 7);
      if (kind < 5) begin
        p    = pick_byte();
        reps = $urandom_range(1, 5);
        repeat (reps) queue_bits(p, 8);
        added += 8 * reps;
      end else if (kind < 7) begin
        nbits = $urandom_range(1, 7);
        queue_bits(byte_t'($urandom_range(0, 255)), nbits);
        added += nbits;
      end else begin
        queue_req(ACT_FLUSH, pick_byte());
        added++;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || s_axis_tvalid || words_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    bool_mode_q = m;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h, want %h (result word %0d)", what, got, want, words_seen);
    mismatches++;
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    enc_req_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_request(s_axis_tuser[0], s_axis_tdata);
        reqs_sent++;
        if (s_axis_tuser[0] == ACT_FLUSH) flushes_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_wait > 0) begin
          src_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          nxt = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= nxt.act;
          s_axis_tdata  <= nxt.val;
          src_wait = pick_wait(calm_src);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- long hold-off
  always @(posedge clk) begin
    if (!rst && hold_armed && hold_cycles < HOLD_LEN) hold_cycles <= hold_cycles + 1;
  end

  assign long_hold = hold_armed && hold_cycles < HOLD_LEN;

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    rle_word_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        words_seen++;
        if (words_due.size() == 0) begin
          report_mismatch("result with nothing due", m_axis_tdata[63:0], '0);
        end else begin
          want = words_due.pop_front();
          if (m_axis_tdata[63:0] !== want.word)
            report_mismatch("out_word", m_axis_tdata[63:0], want.word);
          if (m_axis_tdata[67:64] !== want.nbytes)
            report_mismatch("byte_count", 64'(m_axis_tdata[67:64]), 64'(want.nbytes));
          if (m_axis_tdata[71:68] !== 4'h0)
            report_mismatch("pad bits", 64'(m_axis_tdata[71:68]), '0);
          if (m_axis_tlast !== want.last)
            report_mismatch("last", 64'(m_axis_tlast), 64'(want.last));
        end
        snk_wait = pick_wait(calm_snk);
      end
      m_axis_tready <= !long_hold && snk_wait == 0;
      if (!long_hold && snk_wait > 0) snk_wait--;
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d result words outstanding",
               cycle_cnt, words_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // byte mode: extremes, literal into run, run from the start, flushes
    set_mode(1'b0);
    queue_req(ACT_DATA, 8'h00);
    queue_run(8'hFF, 3);
    queue_req(ACT_DATA, 8'h7F);
    queue_req(ACT_FLUSH, 8'h00);
    queue_req(ACT_FLUSH, 8'hFF);      // nothing pending
    queue_run(8'hAA, 3);
    queue_req(ACT_FLUSH, 8'h00);

    // boolean mode: a full byte, then a flush with a partial byte
    set_mode(1'b1);
    queue_bits(8'hB2, 8);
    queue_bits(8'hC0, 2);
    queue_req(ACT_FLUSH, 8'hFF);
    queue_bits(8'h80, 2);             // left in the accumulator across the mode change

    set_mode(1'b0);
    queue_req(ACT_DATA, 8'h10);
    queue_req(ACT_FLUSH, 8'h00);

    // random byte stream with both caps; output held off at the start
    wait_drained();
    @(posedge clk);
    hold_armed <= 1'b1;
    queue_byte_stream(250, 1'b1);
    queue_req(ACT_FLUSH, 8'h00);

    set_mode(1'b1);
    queue_bit_stream(110);

    set_mode(1'b0);
    queue_byte_stream(40, 1'b0);
    queue_req(ACT_FLUSH, 8'h00);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (words_due.size() != 0) begin
      $display("%0d result words never arrived", words_due.size());
      mismatches++;
    end

    $display("Sent %0d requests (%0d flushes) in byte and boolean mode, incl. caps,",
             reqs_sent, flushes_sent);
    $display("mode changes and a %0d-cycle output hold-off; %0d result words, %0d mismatches",
             HOLD_LEN, words_seen, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/brle_pkg.sv
sv/brle_ram.sv
sv/byte_run_length_encoder_core.sv
sim/byte_run_length_encoder_core_test.sv
